FILE: rtl/core/stat_pkg.sv
// Shared types and codes for the section table address translator.
package stat_pkg;

    localparam int ADDR_W    = 32;
    localparam int OP_W      = 2;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;
    localparam int CFG_IDX_W = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_XLATE  = 2'd1;
    localparam logic [OP_W-1:0] OP_WINDOW = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_BYTES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_COUNT = 2'd2;

    // Command payload
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  entry_index;
        logic [ADDR_W-1:0] virt_start;
        logic [ADDR_W-1:0] virt_size;
        logic [ADDR_W-1:0] raw_base;
        logic [ADDR_W-1:0] raw_length;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] radius;
    } req_t;

    // Result payload
    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] raw_offset;
        logic [ADDR_W-1:0] window_first;
        logic [ADDR_W-1:0] window_last;
    } rsp_t;

    // One table slot, with the region ends precomputed at load time
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] rsize;
        logic [ADDR_W-1:0] top;    // start + window size - 1
        logic [ADDR_W-1:0] t_end;  // start + max(vsize, rsize)
        logic [ADDR_W-1:0] w_end;  // start + window size
        logic              w_nz;   // window size is nonzero
    } entry_t;

    // Fields of the selected slot needed after the pick
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] rsize;
        logic [ADDR_W-1:0] top;
    } read_t;

    // Query state handed from the pick stage to the resolve stages
    typedef struct packed {
        logic              valid;
        logic [OP_W-1:0]   op;
        logic              load_ok;
        logic              in_hdr;
        logic              hdr_x_ok;
        logic              any;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] hdr_b;
        read_t             rd;
    } query_t;

endpackage

FILE: rtl/core/stat_table.sv
// Region table lanes: storage, parallel range match and one-hot read.
module stat_table #(
    parameter int DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [stat_pkg::IDX_W-1:0]    wr_idx,
    input  stat_pkg::entry_t              wr_entry,
    input  logic [stat_pkg::ADDR_W-1:0]   addr,
    input  logic                          sel_window,
    input  logic [stat_pkg::CNT_W-1:0]    live_count,
    output logic [DEPTH-1:0]              hit,
    input  logic [DEPTH-1:0]              rd_sel,
    output stat_pkg::read_t               rd_entry
);

    stat_pkg::entry_t lane_reg [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_lane
            logic live;
            logic t_hit;
            logic w_hit;

            // Slot write, one lane per index
            always_ff @(posedge clk)
            begin
                if (wr_en && (32'(wr_idx) == 32'(i)))
                begin
                    lane_reg[i] <= wr_entry;
                end
            end

            // Range match for this lane
            assign live  = 32'(live_count) > 32'(i);
            assign t_hit = (addr >= lane_reg[i].start) && (addr < lane_reg[i].t_end);
            assign w_hit = lane_reg[i].w_nz && (addr >= lane_reg[i].start)
                           && (addr < lane_reg[i].w_end);
            assign hit[i] = live && (sel_window ? w_hit : t_hit);
        end
    endgenerate

    // AND-OR read of the picked lane
    always_comb
    begin
        rd_entry = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            rd_entry.start = rd_entry.start | ({stat_pkg::ADDR_W{rd_sel[k]}} & lane_reg[k].start);
            rd_entry.base  = rd_entry.base  | ({stat_pkg::ADDR_W{rd_sel[k]}} & lane_reg[k].base);
            rd_entry.rsize = rd_entry.rsize | ({stat_pkg::ADDR_W{rd_sel[k]}} & lane_reg[k].rsize);
            rd_entry.top   = rd_entry.top   | ({stat_pkg::ADDR_W{rd_sel[k]}} & lane_reg[k].top);
        end
    end

endmodule

FILE: rtl/core/stat_resolve.sv
// Final two stages: offset and window arithmetic, then the result register.
module stat_resolve (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [stat_pkg::ADDR_W-1:0] image_bytes,
    input  stat_pkg::query_t            q,
    output logic                        done,
    output stat_pkg::rsp_t              rsp
);

    typedef struct packed {
        logic                        valid;
        logic [stat_pkg::OP_W-1:0]   op;
        logic                        load_ok;
        logic                        in_hdr;
        logic                        hdr_x_ok;
        logic                        any;
        logic [stat_pkg::ADDR_W-1:0] addr;
        logic [stat_pkg::ADDR_W-1:0] base;
        logic [stat_pkg::ADDR_W-1:0] delta;
        logic                        delta_ok;
        logic [stat_pkg::ADDR_W-1:0] wa;
        logic [stat_pkg::ADDR_W-1:0] wb;
        logic                        w_found;
    } s4_t;

    s4_t                         s4_next;
    s4_t                         s4_reg;
    logic [stat_pkg::ADDR_W-1:0] reg_a;
    logic [stat_pkg::ADDR_W-1:0] reg_b;
    logic [stat_pkg::ADDR_W:0]   sum;
    stat_pkg::rsp_t              rsp_next;
    stat_pkg::rsp_t              rsp_reg;
    logic                        done_reg;

    // Stage 4: distance into region and clamped window bounds
    always_comb
    begin
        reg_a             = (q.rd.start > q.lo) ? q.rd.start : q.lo;
        reg_b             = (q.rd.top < q.hi) ? q.rd.top : q.hi;
        s4_next.valid     = q.valid;
        s4_next.op        = q.op;
        s4_next.load_ok   = q.load_ok;
        s4_next.in_hdr    = q.in_hdr;
        s4_next.hdr_x_ok  = q.hdr_x_ok;
        s4_next.any       = q.any;
        s4_next.addr      = q.addr;
        s4_next.base      = q.rd.base;
        s4_next.delta     = q.addr - q.rd.start;
        s4_next.delta_ok  = (q.addr - q.rd.start) < q.rd.rsize;
        s4_next.wa        = q.in_hdr ? q.lo : reg_a;
        s4_next.wb        = q.in_hdr ? q.hdr_b : reg_b;
        s4_next.w_found   = q.in_hdr | q.any;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_reg <= '0;
        end
        else
        begin
            s4_reg <= s4_next;
        end
    end

    // Stage 5: raw offset check and result select; failures give zeros
    assign sum = {1'b0, s4_reg.base} + {1'b0, s4_reg.delta};

    always_comb
    begin
        rsp_next = '0;
        case (s4_reg.op)
            stat_pkg::OP_LOAD:
            begin
                rsp_next.ok = s4_reg.load_ok;
            end
            stat_pkg::OP_XLATE:
            begin
                if (s4_reg.in_hdr)
                begin
                    if (s4_reg.hdr_x_ok)
                    begin
                        rsp_next.ok         = 1'b1;
                        rsp_next.raw_offset = s4_reg.addr;
                    end
                end
                else if (s4_reg.any && s4_reg.delta_ok && (sum < {1'b0, image_bytes}))
                begin
                    rsp_next.ok         = 1'b1;
                    rsp_next.raw_offset = sum[stat_pkg::ADDR_W-1:0];
                end
            end
            stat_pkg::OP_WINDOW:
            begin
                if (s4_reg.w_found && !(s4_reg.wb < s4_reg.wa))
                begin
                    rsp_next.ok           = 1'b1;
                    rsp_next.window_first = s4_reg.wa;
                    rsp_next.window_last  = s4_reg.wb;
                end
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            rsp_reg  <= '0;
        end
        else
        begin
            done_reg <= s4_reg.valid;
            rsp_reg  <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

FILE: rtl/core/section_table_address_translator_top.sv
// Top level of the section table address translator pipeline.
//
// Usage: write header_size, image_bytes and region_count through the cfg
// channel (cfg_ready is always high; index 0, 1, 2, others ignored) while
// no command is in flight. A command transfers at a rising edge with start
// high and busy low; req.op selects load slot, translate or window.
// Each command gives exactly one result: done is high for one cycle with
// rsp valid, and the result transfers at the edge that ends that cycle.
// Throughput: one command per cycle while busy is low; six register
// stages, with every table lane compared in parallel and the first match
// picked in one stage.
// A load writes its slot at the end of stage 2, so any later command
// sees it and any earlier one does not.
// Reset: config registers clear to zero, the pipeline empties, busy is high
// for the first cycle after reset and low from then on. Table contents are
// not cleared; a slot reads as garbage until loaded.
// The receiver cannot stall; results are never held back.
module section_table_address_translator_top #(
    parameter int MAX_REGIONS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [stat_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [stat_pkg::ADDR_W-1:0]    cfg_data,
    input  logic                           start,
    output logic                           busy,
    input  stat_pkg::req_t                 req,
    output logic                           done,
    output stat_pkg::rsp_t                 rsp
);

    typedef struct packed {
        logic [stat_pkg::OP_W-1:0]   op;
        logic [stat_pkg::IDX_W-1:0]  idx;
        logic                        load_ok;
        logic [stat_pkg::ADDR_W-1:0] start;
        logic [stat_pkg::ADDR_W-1:0] base;
        logic [stat_pkg::ADDR_W-1:0] rsize;
        logic [stat_pkg::ADDR_W-1:0] span;
        logic [stat_pkg::ADDR_W-1:0] sz;
        logic [stat_pkg::ADDR_W-1:0] szm1;
        logic                        nz;
        logic [stat_pkg::ADDR_W-1:0] addr;
        logic                        in_hdr;
        logic                        hdr_x_ok;
        logic [stat_pkg::ADDR_W-1:0] lo;
        logic [stat_pkg::ADDR_W-1:0] hi;
        logic [stat_pkg::ADDR_W-1:0] cap;
    } s1_t;

    typedef struct packed {
        logic [stat_pkg::OP_W-1:0]   op;
        logic                        load_ok;
        logic                        in_hdr;
        logic                        hdr_x_ok;
        logic [stat_pkg::ADDR_W-1:0] addr;
        logic [stat_pkg::ADDR_W-1:0] lo;
        logic [stat_pkg::ADDR_W-1:0] hi;
        logic [stat_pkg::ADDR_W-1:0] hdr_b;
    } s2_t;

    logic                          busy_reg;
    logic [stat_pkg::ADDR_W-1:0]   header_size_reg;
    logic [stat_pkg::ADDR_W-1:0]   image_bytes_reg;
    logic [stat_pkg::CNT_W-1:0]    region_count_reg;
    logic                          accept;

    logic                          s0_valid_reg;
    stat_pkg::req_t                s0_req_reg;
    s1_t                           s1_next;
    s1_t                           s1_reg;
    logic                          s1_valid_reg;
    s2_t                           s2_next;
    s2_t                           s2_reg;
    logic                          s2_valid_reg;
    logic [MAX_REGIONS-1:0]        hit;
    logic [MAX_REGIONS-1:0]        s2_hit_reg;
    logic [MAX_REGIONS-1:0]        first_hit;
    logic [stat_pkg::ADDR_W:0]     diff;
    logic                          wr_en;
    stat_pkg::entry_t              wr_entry;
    stat_pkg::read_t               rd_entry;
    stat_pkg::query_t              q_next;
    stat_pkg::query_t              q_reg;

    assign cfg_ready = 1'b1;
    assign busy      = busy_reg;
    assign accept    = start && !busy_reg;

    // Out-of-reset hold and config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b1;
            header_size_reg  <= '0;
            image_bytes_reg  <= '0;
            region_count_reg <= '0;
        end
        else
        begin
            busy_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    stat_pkg::CFG_HEADER_SIZE:  header_size_reg  <= cfg_data;
                    stat_pkg::CFG_IMAGE_BYTES:  image_bytes_reg  <= cfg_data;
                    stat_pkg::CFG_REGION_COUNT:
                        region_count_reg <= cfg_data[stat_pkg::CNT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Stage 0: command capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_req_reg <= req;
        end
    end

    // Stage 1: region sizes for loads, window edges and header tests
    assign diff = {1'b0, s0_req_reg.address} - {1'b0, s0_req_reg.radius};

    always_comb
    begin
        s1_next.op       = s0_req_reg.op;
        s1_next.idx      = s0_req_reg.entry_index;
        s1_next.load_ok  = 32'(s0_req_reg.entry_index) < 32'(MAX_REGIONS);
        s1_next.start    = s0_req_reg.virt_start;
        s1_next.base     = s0_req_reg.raw_base;
        s1_next.rsize    = s0_req_reg.raw_length;
        s1_next.span     = (s0_req_reg.virt_size > s0_req_reg.raw_length)
                           ? s0_req_reg.virt_size : s0_req_reg.raw_length;
        s1_next.sz       = (s0_req_reg.raw_length != '0)
                           ? s0_req_reg.raw_length : s0_req_reg.virt_size;
        s1_next.szm1     = s1_next.sz - 32'd1;
        s1_next.nz       = s1_next.sz != '0;
        s1_next.addr     = s0_req_reg.address;
        s1_next.in_hdr   = s0_req_reg.address < header_size_reg;
        s1_next.hdr_x_ok = s0_req_reg.address < image_bytes_reg;
        s1_next.lo       = diff[stat_pkg::ADDR_W] ? '0 : diff[stat_pkg::ADDR_W-1:0];
        s1_next.hi       = s0_req_reg.address + s0_req_reg.radius;
        s1_next.cap      = header_size_reg - 32'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
    end

    // Stage 2: slot write for loads, lane match for queries
    assign wr_en          = s1_valid_reg && (s1_reg.op == stat_pkg::OP_LOAD) && s1_reg.load_ok;
    assign wr_entry.start = s1_reg.start;
    assign wr_entry.base  = s1_reg.base;
    assign wr_entry.rsize = s1_reg.rsize;
    assign wr_entry.top   = s1_reg.start + s1_reg.szm1;
    assign wr_entry.t_end = s1_reg.start + s1_reg.span;
    assign wr_entry.w_end = s1_reg.start + s1_reg.sz;
    assign wr_entry.w_nz  = s1_reg.nz;

    stat_table #(
        .DEPTH (MAX_REGIONS)
    ) u_table (
        .clk        (clk),
        .wr_en      (wr_en),
        .wr_idx     (s1_reg.idx),
        .wr_entry   (wr_entry),
        .addr       (s1_reg.addr),
        .sel_window (s1_reg.op == stat_pkg::OP_WINDOW),
        .live_count (region_count_reg),
        .hit        (hit),
        .rd_sel     (first_hit),
        .rd_entry   (rd_entry)
    );

    always_comb
    begin
        s2_next.op       = s1_reg.op;
        s2_next.load_ok  = s1_reg.load_ok;
        s2_next.in_hdr   = s1_reg.in_hdr;
        s2_next.hdr_x_ok = s1_reg.hdr_x_ok;
        s2_next.addr     = s1_reg.addr;
        s2_next.lo       = s1_reg.lo;
        s2_next.hi       = s1_reg.hi;
        s2_next.hdr_b    = (s1_reg.hi < s1_reg.cap) ? s1_reg.hi : s1_reg.cap;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_reg     <= s2_next;
        s2_hit_reg <= hit;
    end

    // Stage 3: first matching lane and its fields
    assign first_hit = s2_hit_reg & ~(s2_hit_reg - MAX_REGIONS'(1));

    always_comb
    begin
        q_next.valid    = s2_valid_reg;
        q_next.op       = s2_reg.op;
        q_next.load_ok  = s2_reg.load_ok;
        q_next.in_hdr   = s2_reg.in_hdr;
        q_next.hdr_x_ok = s2_reg.hdr_x_ok;
        q_next.any      = |s2_hit_reg;
        q_next.addr     = s2_reg.addr;
        q_next.lo       = s2_reg.lo;
        q_next.hi       = s2_reg.hi;
        q_next.hdr_b    = s2_reg.hdr_b;
        q_next.rd       = rd_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    // Stages 4 and 5
    stat_resolve u_resolve (
        .clk         (clk),
        .rst_n       (rst_n),
        .image_bytes (image_bytes_reg),
        .q           (q_reg),
        .done        (done),
        .rsp         (rsp)
    );

endmodule

FILE: rtl/core/stat_checker.sv
// Port-level checks for the translator top, bound in below.
module stat_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input stat_pkg::req_t req,
    input logic           done,
    input stat_pkg::rsp_t rsp
);

    // Every transfer in gives a result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##6 done)
        else $error("command transfer without a result");

    // No result without an earlier command
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 6))
        else $error("result without a command");

    // A load reports no offset or window
    a_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.op == stat_pkg::OP_LOAD) |-> ##6
        (rsp.raw_offset == '0 && rsp.window_first == '0 && rsp.window_last == '0))
        else $error("load result carries data");

    // A failed result is all zeros
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !rsp.ok) |->
        (rsp.raw_offset == '0 && rsp.window_first == '0 && rsp.window_last == '0))
        else $error("failed result carries data");

    // busy only stands in the cycle after reset
    a_busy_once: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held");

endmodule

bind section_table_address_translator_top stat_checker u_stat_checker (.*);
